[hw/rtl/bblur_pkg.sv]
// Shared constants, types and helper functions for the 3x3 box blur block.
package bblur_pkg;

   // Geometry limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int COL_W      = ADDR_W;
   localparam int WUSE_W     = $clog2(MAX_WIDTH + 2);
   localparam int HUSE_W     = 13;
   localparam int ROW_W      = 12;

   // Register file
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Request kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // Pixel and arithmetic
   localparam int CH_W        = 8;
   localparam int PIX_W       = 4 * CH_W;
   localparam int SUM_W       = 12;
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 15;
   localparam int PROD_W      = SUM_W + RECIP_W;
   // floor(s * RECIP >> 15) == s / n for every s up to 9 * 255
   localparam logic [RECIP_W-1:0] RECIP_DIV4 = RECIP_W'(8192);
   localparam logic [RECIP_W-1:0] RECIP_DIV6 = RECIP_W'(5462);
   localparam logic [RECIP_W-1:0] RECIP_DIV9 = RECIP_W'(3641);

   // Result queue
   localparam int OFIFO_DEPTH = 4;

   typedef struct packed {
      logic [CH_W-1:0] alpha;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } pix_type;

   // Decoded work for one item, handed from the sequencer to the window stage
   typedef struct packed {
      logic              valid;
      logic              emit;
      logic              slide;
      logic              store;
      logic              top_ok;
      logic              bot_ok;
      logic              left_ok;
      logic              right_ok;
      logic              frame_end;
      logic [ADDR_W-1:0] addr;
      pix_type           pix;
   } slot_type;

   // Masked neighborhood sums, handed from the window stage to the divider
   typedef struct packed {
      logic               valid;
      logic [SUM_W-1:0]   sum_red;
      logic [SUM_W-1:0]   sum_green;
      logic [SUM_W-1:0]   sum_blue;
      logic [RECIP_W-1:0] recip;
      logic [CH_W-1:0]    alpha;
      logic               frame_end;
   } sums_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
      logic            frame_end;
   } result_type;

   // Reciprocal for the pixel count: 2 or 3 rows times 2 or 3 columns
   function automatic logic [RECIP_W-1:0] recip_for(input logic rows3, input logic cols3);
      logic [RECIP_W-1:0] r;
      case ({rows3, cols3})
         2'b11:   r = RECIP_DIV9;
         2'b00:   r = RECIP_DIV4;
         default: r = RECIP_DIV6;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/bblur_ifs.sv]
// Handshake channel interfaces: pixel requests, blurred results, register writes.
interface bblur_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [bblur_pkg::CH_W-1:0] in_red;
   logic [bblur_pkg::CH_W-1:0] in_green;
   logic [bblur_pkg::CH_W-1:0] in_blue;
   logic [bblur_pkg::CH_W-1:0] in_alpha;

   modport source (output valid, req_type, in_red, in_green, in_blue, in_alpha,
                   input ready);
   modport sink (input valid, req_type, in_red, in_green, in_blue, in_alpha,
                 output ready);
endinterface

interface bblur_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bblur_pkg::CH_W-1:0] out_red;
   logic [bblur_pkg::CH_W-1:0] out_green;
   logic [bblur_pkg::CH_W-1:0] out_blue;
   logic [bblur_pkg::CH_W-1:0] out_alpha;
   logic                        frame_end;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                 output ready);
endinterface

interface bblur_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bblur_pkg::CSR_IDX_W-1:0]  index;
   logic [bblur_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/bblur_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bblur_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bblur_ctrl.sv]
// Sequencer: registers, raster position, drain count and per-beat decode.
module bblur_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   bblur_req_if.sink                    req,
   bblur_csr_if.sink                    csr,
   input  logic                         room,
   output logic                         rd_en,
   output logic [bblur_pkg::ADDR_W-1:0] rd_addr,
   output bblur_pkg::slot_type          slot
);

   logic [bblur_pkg::WUSE_W-1:0] wuse_ff, wuse_in;
   logic [bblur_pkg::HUSE_W-1:0] huse_ff, huse_in;
   logic [bblur_pkg::COL_W-1:0]  col_ff, col_in;
   logic [bblur_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [bblur_pkg::WUSE_W-1:0] pend_ff, pend_in;
   bblur_pkg::slot_type          slot_ff, slot_in;

   logic                              accept;
   logic                              csr_fire;
   logic                              last_col;
   logic                              last_row;
   logic                              emit_wrap;
   logic                              emit_body;
   logic                              flush_live;
   logic                              k_first;
   logic                              k_last;
   logic [bblur_pkg::WUSE_W-1:0]      k;
   logic [bblur_pkg::CFG_WIDTH_W-1:0]  cfg_w;
   logic [bblur_pkg::CFG_HEIGHT_W-1:0] cfg_h;
   logic [bblur_pkg::WUSE_W-1:0]      w_clamp;
   logic [bblur_pkg::HUSE_W-1:0]      h_clamp;

   // handshakes
   assign req.ready = room;
   assign csr.ready = 1'b1;
   assign accept    = req.valid & req.ready;
   assign csr_fire  = csr.valid & csr.ready;

   // position flags
   assign last_col   = (bblur_pkg::WUSE_W'(col_ff) == wuse_ff - bblur_pkg::WUSE_W'(1));
   assign last_row   = (bblur_pkg::HUSE_W'(row_ff) == huse_ff - bblur_pkg::HUSE_W'(1));
   assign emit_wrap  = (col_ff == '0) && (row_ff >= bblur_pkg::ROW_W'(2));
   assign emit_body  = (col_ff != '0) && (row_ff != '0);
   assign flush_live = (pend_ff != '0);
   assign k          = wuse_ff + bblur_pkg::WUSE_W'(1) - pend_ff;
   assign k_first    = (k == '0);
   assign k_last     = (k == wuse_ff);

   // register clamping
   always_comb begin
      cfg_w = csr.data[bblur_pkg::CFG_WIDTH_W-1:0];
      cfg_h = csr.data[bblur_pkg::CFG_HEIGHT_W-1:0];
      if (cfg_w < bblur_pkg::CFG_WIDTH_W'(2)) begin
         w_clamp = bblur_pkg::WUSE_W'(2);
      end else if (int'(cfg_w) > bblur_pkg::MAX_WIDTH) begin
         w_clamp = bblur_pkg::WUSE_W'(bblur_pkg::MAX_WIDTH);
      end else begin
         w_clamp = bblur_pkg::WUSE_W'(cfg_w);
      end
      if (cfg_h < bblur_pkg::CFG_HEIGHT_W'(2)) begin
         h_clamp = bblur_pkg::HUSE_W'(2);
      end else if (int'(cfg_h) > bblur_pkg::MAX_HEIGHT) begin
         h_clamp = bblur_pkg::HUSE_W'(bblur_pkg::MAX_HEIGHT);
      end else begin
         h_clamp = bblur_pkg::HUSE_W'(cfg_h);
      end
   end

   // decode the beat into window work
   always_comb begin
      slot_in           = '0;
      slot_in.pix.red   = req.in_red;
      slot_in.pix.green = req.in_green;
      slot_in.pix.blue  = req.in_blue;
      slot_in.pix.alpha = req.in_alpha;
      slot_in.addr      = col_ff;
      if (req.req_type == bblur_pkg::REQ_PIXEL) begin
         slot_in.valid    = accept;
         slot_in.emit     = emit_wrap | emit_body;
         slot_in.slide    = 1'b1;
         slot_in.store    = 1'b1;
         // wrap result is the previous row's last column
         slot_in.top_ok   = emit_wrap ? (row_ff >= bblur_pkg::ROW_W'(3))
                                      : (row_ff >= bblur_pkg::ROW_W'(2));
         slot_in.bot_ok   = 1'b1;
         slot_in.left_ok  = emit_wrap | (col_ff >= bblur_pkg::COL_W'(2));
         slot_in.right_ok = ~emit_wrap;
      end else begin
         // drain: last-but-one row's end, then the bottom row
         slot_in.valid     = accept & flush_live;
         slot_in.emit      = flush_live;
         slot_in.slide     = flush_live & ~k_last;
         slot_in.top_ok    = k_first ? (huse_ff >= bblur_pkg::HUSE_W'(3)) : 1'b1;
         slot_in.bot_ok    = k_first;
         slot_in.left_ok   = k_first | k_last | (k >= bblur_pkg::WUSE_W'(2));
         slot_in.right_ok  = ~(k_first | k_last);
         slot_in.frame_end = k_last;
         slot_in.addr      = k[bblur_pkg::ADDR_W-1:0];
         slot_in.pix       = '0;
      end
   end

   assign rd_en   = slot_in.valid & slot_in.slide;
   assign rd_addr = slot_in.addr;

   // next position, drain count and registers
   always_comb begin
      wuse_in = wuse_ff;
      huse_in = huse_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (csr_fire) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
         if (csr.index == bblur_pkg::CSR_IMAGE_WIDTH) begin
            wuse_in = w_clamp;
         end else if (csr.index == bblur_pkg::CSR_IMAGE_HEIGHT) begin
            huse_in = h_clamp;
         end else begin
            col_in  = col_ff;
            row_in  = row_ff;
            pend_in = pend_ff;
         end
      end else if (accept) begin
         if (req.req_type == bblur_pkg::REQ_PIXEL) begin
            pend_in = '0;
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  row_in  = '0;
                  pend_in = wuse_ff + bblur_pkg::WUSE_W'(1);
               end else begin
                  row_in = row_ff + bblur_pkg::ROW_W'(1);
               end
            end else begin
               col_in = col_ff + bblur_pkg::COL_W'(1);
            end
         end else if (flush_live) begin
            pend_in = pend_ff - bblur_pkg::WUSE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wuse_ff       <= bblur_pkg::WUSE_W'(bblur_pkg::RESET_WIDTH);
         huse_ff       <= bblur_pkg::HUSE_W'(bblur_pkg::RESET_HEIGHT);
         col_ff        <= '0;
         row_ff        <= '0;
         pend_ff       <= '0;
         slot_ff.valid <= 1'b0;
      end else begin
         wuse_ff <= wuse_in;
         huse_ff <= huse_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

   // checks
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      bblur_pkg::WUSE_W'(col_ff) < wuse_ff)
      else $error("column position past row end");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= wuse_ff + bblur_pkg::WUSE_W'(1))
      else $error("drain count exceeds row length plus one");

   a_drain_at_origin: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |-> (col_ff == '0 && row_ff == '0))
      else $error("drain pending while mid-frame");

endmodule

[hw/rtl/bblur_window.sv]
// Window stage: line buffer read-modify-write, 3x3 window and masked sums.
module bblur_window (
   input  logic                         clock,
   input  logic                         reset,
   input  bblur_pkg::slot_type          slot,
   input  logic                         rd_en,
   input  logic [bblur_pkg::ADDR_W-1:0] rd_addr,
   input  bblur_pkg::pix_type           older_rdata,
   input  bblur_pkg::pix_type           newer_rdata,
   output logic                         wr_en,
   output logic [bblur_pkg::ADDR_W-1:0] wr_addr,
   output bblur_pkg::pix_type           older_wdata,
   output bblur_pkg::pix_type           newer_wdata,
   output bblur_pkg::sums_type          sums
);

   bblur_pkg::pix_type  win_ff [0:2][0:2];
   bblur_pkg::pix_type  view   [0:2][0:2];
   bblur_pkg::pix_type  top_pix;
   bblur_pkg::pix_type  mid_pix;
   bblur_pkg::pix_type  fwd_older_ff;
   bblur_pkg::pix_type  fwd_newer_ff;
   logic                fwd_hit_ff, fwd_hit_in;
   bblur_pkg::sums_type sums_ff, sums_in;
   logic [2:0]          row_use;
   logic [2:0]          col_use;

   // line buffer data, bypassed when written on the edge it was read
   assign top_pix = fwd_hit_ff ? fwd_older_ff : older_rdata;
   assign mid_pix = fwd_hit_ff ? fwd_newer_ff : newer_rdata;

   // shift in the new column; center is always view column 1
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         view[r][0] = win_ff[r][1];
         view[r][1] = win_ff[r][2];
      end
      view[0][2] = top_pix;
      view[1][2] = mid_pix;
      view[2][2] = slot.pix;
   end

   // line buffer write back: rows move up by one
   assign wr_en       = slot.valid & slot.store;
   assign wr_addr     = slot.addr;
   assign older_wdata = mid_pix;
   assign newer_wdata = slot.pix;
   assign fwd_hit_in  = wr_en & rd_en & (wr_addr == rd_addr);

   // masked sums over the neighborhood
   assign row_use = {slot.bot_ok, 1'b1, slot.top_ok};
   assign col_use = {slot.right_ok, 1'b1, slot.left_ok};

   always_comb begin
      sums_in           = '0;
      sums_in.valid     = slot.valid & slot.emit;
      sums_in.frame_end = slot.frame_end;
      sums_in.alpha     = view[1][1].alpha;
      sums_in.recip     = bblur_pkg::recip_for(slot.top_ok & slot.bot_ok,
                                               slot.left_ok & slot.right_ok);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (row_use[r] && col_use[c]) begin
               sums_in.sum_red   = sums_in.sum_red + bblur_pkg::SUM_W'(view[r][c].red);
               sums_in.sum_green = sums_in.sum_green + bblur_pkg::SUM_W'(view[r][c].green);
               sums_in.sum_blue  = sums_in.sum_blue + bblur_pkg::SUM_W'(view[r][c].blue);
            end
         end
      end
   end

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (slot.valid && slot.slide) begin
         win_ff <= view;
      end
   end

   // bypass and stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff    <= 1'b0;
         sums_ff.valid <= 1'b0;
      end else begin
         fwd_hit_ff <= fwd_hit_in;
         sums_ff    <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_older_ff <= older_wdata;
      fwd_newer_ff <= newer_wdata;
   end

   assign sums = sums_ff;

endmodule

[hw/rtl/bblur_outq.sv]
// Divide stage and result queue feeding the response channel.
module bblur_outq (
   input  logic                clock,
   input  logic                reset,
   input  bblur_pkg::sums_type sums,
   input  logic                slot_emit,
   output logic                room,
   bblur_rsp_if.source         rsp
);

   localparam int PTR_W = $clog2(bblur_pkg::OFIFO_DEPTH);
   localparam int CNT_W = $clog2(bblur_pkg::OFIFO_DEPTH + 1);

   bblur_pkg::result_type q_ff [0:bblur_pkg::OFIFO_DEPTH-1];
   bblur_pkg::result_type res_in;
   bblur_pkg::result_type head;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W:0]        occupancy;
   logic [bblur_pkg::PROD_W-1:0] prod_red;
   logic [bblur_pkg::PROD_W-1:0] prod_green;
   logic [bblur_pkg::PROD_W-1:0] prod_blue;
   logic                  push;
   logic                  pop;

   // divide by the pixel count via reciprocal multiply
   assign prod_red   = bblur_pkg::PROD_W'(sums.sum_red) * bblur_pkg::PROD_W'(sums.recip);
   assign prod_green = bblur_pkg::PROD_W'(sums.sum_green) * bblur_pkg::PROD_W'(sums.recip);
   assign prod_blue  = bblur_pkg::PROD_W'(sums.sum_blue) * bblur_pkg::PROD_W'(sums.recip);

   always_comb begin
      res_in.red       = prod_red[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
      res_in.green     = prod_green[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
      res_in.blue      = prod_blue[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
      res_in.alpha     = sums.alpha;
      res_in.frame_end = sums.frame_end;
   end

   // queue bookkeeping; room counts beats still in the pipe
   assign push      = sums.valid;
   assign pop       = rsp.valid & rsp.ready;
   assign occupancy = (CNT_W+1)'(count_ff) + (CNT_W+1)'(sums.valid) + (CNT_W+1)'(slot_emit);
   assign room      = occupancy < (CNT_W+1)'(bblur_pkg::OFIFO_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(bblur_pkg::OFIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(bblur_pkg::OFIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= res_in;
      end
   end

   // response channel
   assign head          = q_ff[rd_ptr_ff];
   assign rsp.valid     = (count_ff != '0);
   assign rsp.out_red   = head.red;
   assign rsp.out_green = head.green;
   assign rsp.out_blue  = head.blue;
   assign rsp.out_alpha = head.alpha;
   assign rsp.frame_end = head.frame_end;

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(bblur_pkg::OFIFO_DEPTH)) || pop)
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(bblur_pkg::OFIFO_DEPTH))
      else $error("result queue count out of range");

endmodule

[hw/rtl/box_blur_3x3_edge_aware.sv]
// Top level of the edge-aware 3x3 box blur over a raster RGBA stream.
//
//   channel   port      direction  beat
//   request   req_bus   in         req_type, in_red, in_green, in_blue, in_alpha
//   result    rsp_bus   out        out_red, out_green, out_blue, out_alpha, frame_end
//   register  csr_bus   in         index, data (0 = image_width, 1 = image_height)
//
// One request beat per clock while req ready is high. A result passes the slot
// register, the sums register and the queue before it leaves; a pixel beat costs
// one read and one write on each line buffer RAM, a drain tick one read at most.
// Reset is synchronous; the line buffers are not cleared and need no clearing pass.
// The result side stalls into a 4-entry queue; req ready drops only once queue
// plus in-flight results reach 4. Register writes are taken every cycle.
module box_blur_3x3_edge_aware (
   input logic         clock,
   input logic         reset,
   bblur_req_if.sink   req_bus,
   bblur_rsp_if.source rsp_bus,
   bblur_csr_if.sink   csr_bus
);

   bblur_pkg::slot_type          slot;
   bblur_pkg::sums_type          sums;
   bblur_pkg::pix_type           older_rdata;
   bblur_pkg::pix_type           newer_rdata;
   bblur_pkg::pix_type           older_wdata;
   bblur_pkg::pix_type           newer_wdata;
   logic                         rd_en;
   logic [bblur_pkg::ADDR_W-1:0] rd_addr;
   logic                         wr_en;
   logic [bblur_pkg::ADDR_W-1:0] wr_addr;
   logic                         room;
   logic                         slot_emit;

   // sequencer
   bblur_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .csr     (csr_bus),
      .room    (room),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .slot    (slot)
   );

   // line buffers: two rows back and one row back
   bblur_ram #(
      .WIDTH (bblur_pkg::PIX_W),
      .DEPTH (bblur_pkg::MAX_WIDTH)
   ) u_ram_older (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (older_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (older_rdata)
   );

   bblur_ram #(
      .WIDTH (bblur_pkg::PIX_W),
      .DEPTH (bblur_pkg::MAX_WIDTH)
   ) u_ram_newer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (newer_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (newer_rdata)
   );

   // window and sums
   bblur_window u_window (
      .clock       (clock),
      .reset       (reset),
      .slot        (slot),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .older_rdata (older_rdata),
      .newer_rdata (newer_rdata),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .older_wdata (older_wdata),
      .newer_wdata (newer_wdata),
      .sums        (sums)
   );

   assign slot_emit = slot.valid & slot.emit;

   // divide and queue
   bblur_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .sums      (sums),
      .slot_emit (slot_emit),
      .room      (room),
      .rsp       (rsp_bus)
   );

endmodule
